/* rtl/tdc_pkg.sv */
// Package for the time-of-day clock: field widths, reset values and shared types.
// No dependencies; used by every other file of the block.
package tdc_pkg;

  localparam int unsigned HourW    = 5;
  localparam int unsigned MinW     = 6;
  localparam int unsigned SecW     = 6;
  localparam int unsigned LevelW   = 2;
  localparam int unsigned BtnW     = 3;
  localparam int unsigned CmpW     = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam int unsigned LevelCount = 4;

  localparam logic [SecW-1:0]  SecLast  = 6'd59;
  localparam logic [MinW-1:0]  MinLast  = 6'd59;
  localparam logic [HourW-1:0] HourLast = 5'd23;

  // button bit positions, active low on the pins
  localparam int unsigned BtnMinute = 0;
  localparam int unsigned BtnHour   = 1;
  localparam int unsigned BtnLevel  = 2;

  localparam logic [BtnW-1:0] BtnReleased = '1;

  typedef logic [CmpW-1:0] cmp_tab_t [LevelCount];

  // reset contents of the compare table, entry i is config register i
  localparam cmp_tab_t CmpReset = '{8'd255, 8'd248, 8'd156, 8'd0};

  typedef struct packed {
    logic [HourW-1:0]  hour;
    logic [MinW-1:0]   minute;
    logic [SecW-1:0]   second;
    logic [LevelW-1:0] level;
  } clk_state_t;

  localparam clk_state_t StateReset = '{hour: 5'd5, minute: 6'd20, second: 6'd0, level: 2'd2};

  typedef struct packed {
    logic            second_tick;
    logic [BtnW-1:0] buttons;
  } sample_t;

  typedef struct packed {
    clk_state_t      state;
    logic [CmpW-1:0] compare;
  } result_t;

endpackage

/* rtl/tdc_if.sv */
// Channel interfaces of the time-of-day clock: sample input and time result output.
// Depends on tdc_pkg for the field widths.
interface tdc_in_if
  import tdc_pkg::*;
;
  logic            valid;
  logic            ready;
  logic            second_tick;
  logic [BtnW-1:0] button_levels;

  modport source (output valid, output second_tick, output button_levels, input ready);
  modport sink   (input valid, input second_tick, input button_levels, output ready);
endinterface

interface tdc_out_if
  import tdc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [HourW-1:0]  hour_count;
  logic [MinW-1:0]   minute_count;
  logic [SecW-1:0]   second_count;
  logic [LevelW-1:0] level_index;
  logic [CmpW-1:0]   pwm_compare;

  modport source (output valid, output hour_count, output minute_count, output second_count,
                  output level_index, output pwm_compare, input ready);
  modport sink   (input valid, input hour_count, input minute_count, input second_count,
                  input level_index, input pwm_compare, output ready);
endinterface

/* rtl/tdc_cfg_regs.sv */
// Brightness compare table: four 8-bit registers written through the config port.
// Depends on tdc_pkg.
module tdc_cfg_regs
  import tdc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [LevelW-1:0]   level_i,
  output logic [CmpW-1:0]     compare_o
);

  cmp_tab_t cmp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_q <= CmpReset;
    end else if (cfg_we_i) begin
      for (int unsigned i = 0; i < LevelCount; i++) begin
        if (cfg_index_i == CfgIdxW'(i)) begin
          cmp_q[i] <= cfg_data_i[CmpW-1:0];
        end
      end
    end
  end

  assign compare_o = cmp_q[level_i];

endmodule

/* rtl/tdc_step.sv */
// Next-state logic of the clock for one sample: tick first, then buttons in order.
// Depends on tdc_pkg.
module tdc_step
  import tdc_pkg::*;
(
  input  clk_state_t      state_i,
  input  logic [BtnW-1:0] last_btn_i,
  input  sample_t         sample_i,
  output clk_state_t      state_o
);

  function automatic clk_state_t bump_hour(clk_state_t s);
    clk_state_t r;
    r = s;
    if (s.hour >= HourLast) begin
      r.hour = '0;
    end else begin
      r.hour = s.hour + 1'b1;
    end
    return r;
  endfunction

  function automatic clk_state_t bump_minute(clk_state_t s);
    clk_state_t r;
    r = s;
    if (s.minute >= MinLast) begin
      r.minute = '0;
      r = bump_hour(r);
    end else begin
      r.minute = s.minute + 1'b1;
    end
    return r;
  endfunction

  logic [BtnW-1:0] falling;

  // released last sample, pressed now
  assign falling = last_btn_i & ~sample_i.buttons;

  always_comb begin
    clk_state_t s;
    s = state_i;
    if (sample_i.second_tick) begin
      if (s.second >= SecLast) begin
        s.second = '0;
        s = bump_minute(s);
      end else begin
        s.second = s.second + 1'b1;
      end
    end
    if (falling[BtnMinute]) begin
      s.second = '0;
      s = bump_minute(s);
    end
    if (falling[BtnHour]) begin
      s = bump_hour(s);
    end
    if (falling[BtnLevel]) begin
      s.level = s.level + 1'b1;  // wraps modulo four
    end
    state_o = s;
  end

endmodule

/* rtl/time_of_day_clock_with_set_buttons_core.sv */
// 24-hour time-of-day clock with minute, hour and brightness set buttons.
// Depends on tdc_pkg, tdc_if, tdc_cfg_regs and tdc_step.
//
// Every input sample gives exactly one result holding the time after the sample and the
// PWM compare value of the current brightness level. One sample is taken per clock cycle
// while the result side is not stalled; a sample register feeds the combinational clock
// update (increment and wrap of seconds, minutes, hours and level), whose output lands in
// the result register. The sample register accepts a new sample while a finished result
// waits to be taken only if it is empty, so at most two items are held inside. The user
// must write the compare table through the config port only while no sample is in
// flight; the block itself does not enforce this.
module time_of_day_clock_with_set_buttons_core
  import tdc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  tdc_in_if.sink              in_i,
  tdc_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  sample_t         in_q;
  logic            in_vq;
  clk_state_t      state_q, state_d;
  logic [BtnW-1:0] last_btn_q;
  result_t         out_q;
  logic            out_vq;
  logic [CmpW-1:0] compare;
  logic            advance;

  assign advance    = in_vq && (!out_vq || out_o.ready);
  assign in_i.ready = !in_vq || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_i.ready) begin
      in_vq <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= '{second_tick: in_i.second_tick, buttons: in_i.button_levels};
    end
  end

  tdc_step u_step (
    .state_i   (state_q),
    .last_btn_i(last_btn_q),
    .sample_i  (in_q),
    .state_o   (state_d)
  );

  tdc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .level_i    (state_d.level),
    .compare_o  (compare)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StateReset;
      last_btn_q <= BtnReleased;
      out_vq     <= 1'b0;
    end else begin
      if (advance) begin
        state_q    <= state_d;
        last_btn_q <= in_q.buttons;
        out_vq     <= 1'b1;
      end else if (out_o.ready) begin
        out_vq <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= '{state: state_d, compare: compare};
    end
  end

  assign out_o.valid        = out_vq;
  assign out_o.hour_count   = out_q.state.hour;
  assign out_o.minute_count = out_q.state.minute;
  assign out_o.second_count = out_q.state.second;
  assign out_o.level_index  = out_q.state.level;
  assign out_o.pwm_compare  = out_q.compare;

endmodule

/* rtl/tdc_checker.sv */
// Port-level checks for the time-of-day clock, bound to the top level.
// Depends on tdc_pkg and time_of_day_clock_with_set_buttons_core.
module tdc_checker
  import tdc_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [HourW-1:0]  hour_count,
  input logic [MinW-1:0]   minute_count,
  input logic [SecW-1:0]   second_count,
  input logic [LevelW-1:0] level_index,
  input logic [CmpW-1:0]   pwm_compare
);

  // a result waits until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable({hour_count, minute_count, second_count,
                                         level_index, pwm_compare}))
    else $error("stalled result changed");

  // input side only stalls behind a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output free");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> hour_count <= HourLast && minute_count <= MinLast &&
                  second_count <= SecLast)
    else $error("time field out of range");

endmodule

bind time_of_day_clock_with_set_buttons_core tdc_checker u_tdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .hour_count  (out_o.hour_count),
  .minute_count(out_o.minute_count),
  .second_count(out_o.second_count),
  .level_index (out_o.level_index),
  .pwm_compare (out_o.pwm_compare)
);

/* test/tb_time_of_day_clock_with_set_buttons_core.sv */
`timescale 1ns / 1ps
// Testbench for time_of_day_clock_with_set_buttons_core: random and directed samples,
// checked against a cycle-free clock predictor. Depends on tdc_pkg, tdc_if and the core.
module tb_time_of_day_clock_with_set_buttons_core
  import tdc_pkg::*;
;

  localparam int PhaseItems = 312;
  localparam int HoldAfter  = 500;
  localparam int HoldCycles = 300;
  localparam int CycleLimit = 200_000;

  typedef enum logic [1:0] {ReadyAlways, ReadyHalf, ReadySparse, ReadyMostly} stall_mode_e;

  logic clk_i;
  logic rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  tdc_in_if  sample_ch ();
  tdc_out_if time_ch ();

  time_of_day_clock_with_set_buttons_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (sample_ch),
    .out_o       (time_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // predicted clock state and compare table
  clk_state_t      clock_now;
  logic [BtnW-1:0] prev_buttons;
  cmp_tab_t        compare_tab;

  sample_t pending_samples[$];
  result_t expected_times[$];

  int fail_count;
  int results_seen;
  int burst_left;
  int gap_left;
  int hold_left;
  int mode_left;
  int cycle_count;
  stall_mode_e stall_mode;
  result_t     want;

  function automatic void bump_hour();
    clock_now.hour = (clock_now.hour == HourLast) ? '0 : clock_now.hour + 1'b1;
  endfunction

  function automatic void bump_minute();
    if (clock_now.minute == MinLast) begin
      clock_now.minute = '0;
      bump_hour();
    end else begin
      clock_now.minute = clock_now.minute + 1'b1;
    end
  endfunction

  function automatic result_t advance_clock(input sample_t smp);
    logic [BtnW-1:0] falling;
    result_t res;
    falling = prev_buttons & ~smp.buttons;
    if (smp.second_tick) begin
      if (clock_now.second == SecLast) begin
        clock_now.second = '0;
        bump_minute();
      end else begin
        clock_now.second = clock_now.second + 1'b1;
      end
    end
    // edges handled in order minute, hour, brightness
    if (falling[BtnMinute]) begin
      clock_now.second = '0;
      bump_minute();
    end
    if (falling[BtnHour]) bump_hour();
    // level is two bits wide, so the add wraps modulo four
    if (falling[BtnLevel]) clock_now.level = clock_now.level + 1'b1;
    prev_buttons = smp.buttons;
    res.state   = clock_now;
    res.compare = compare_tab[clock_now.level];
    return res;
  endfunction

  task automatic push_sample(input logic tick, input logic [BtnW-1:0] levels);
    sample_t smp;
    smp.second_tick = tick;
    smp.buttons     = levels;
    pending_samples.push_back(smp);
  endtask

  task automatic check_field(input string field, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", field, exp_v, act_v);
      fail_count++;
    end
  endtask

  // mostly press/hold/release sequences and tick runs, some raw noise
  task automatic queue_random_samples(input int count);
    int added;
    int len;
    int pick;
    logic [BtnW-1:0] press;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        press = BtnW'($urandom_range(0, 6));
        len = $urandom_range(1, 3);
        repeat (len) push_sample(1'($urandom_range(0, 1)), press);
        added += len;
        len = $urandom_range(1, 2);
        repeat (len) push_sample(1'($urandom_range(0, 1)), BtnReleased);
        added += len;
      end else if (pick < 75) begin
        len = $urandom_range(1, 70);
        repeat (len) push_sample($urandom_range(0, 7) != 0, BtnReleased);
        added += len;
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) push_sample(1'($urandom_range(0, 1)), BtnW'($urandom_range(0, 7)));
        added += len;
      end
    end
  endtask

  task automatic load_compare_table(input cmp_tab_t tab);
    for (int lvl = 0; lvl < LevelCount; lvl++) begin
      @(posedge clk_i);
      cfg_we    <= 1'b1;
      cfg_index <= CfgIdxW'(lvl);
      cfg_data  <= tab[lvl];
      compare_tab[lvl] = tab[lvl];
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || expected_times.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sample driver: bursts of random length with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_ch.valid         <= 1'b0;
      sample_ch.second_tick   <= 1'b0;
      sample_ch.button_levels <= BtnReleased;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        expected_times.push_back(advance_clock(pending_samples.pop_front()));
        if (burst_left > 0) burst_left--;
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (gap_left > 0) begin
        gap_left--;
        sample_ch.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        sample_ch.valid         <= 1'b1;
        sample_ch.second_tick   <= pending_samples[0].second_tick;
        sample_ch.button_levels <= pending_samples[0].buttons;
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor with its own stall pattern and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_ch.ready <= 1'b0;
      hold_left  = 0;
      mode_left  = 0;
      stall_mode = ReadyAlways;
    end else begin
      if (time_ch.valid && time_ch.ready) begin
        if (expected_times.size() == 0) begin
          $error("result transfer with no expected time pending");
          fail_count++;
        end else begin
          want = expected_times.pop_front();
          check_field("hour_count", 32'(want.state.hour), 32'(time_ch.hour_count));
          check_field("minute_count", 32'(want.state.minute), 32'(time_ch.minute_count));
          check_field("second_count", 32'(want.state.second), 32'(time_ch.second_count));
          check_field("level_index", 32'(want.state.level), 32'(time_ch.level_index));
          check_field("pwm_compare", 32'(want.compare), 32'(time_ch.pwm_compare));
        end
        results_seen++;
        if (results_seen == HoldAfter) hold_left = HoldCycles;
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        time_ch.ready <= 1'b0;
      end else begin
        case (stall_mode)
          ReadyAlways: time_ch.ready <= 1'b1;
          ReadyHalf:   time_ch.ready <= 1'($urandom_range(0, 1));
          ReadySparse: time_ch.ready <= ($urandom_range(0, 3) == 0);
          default:     time_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    cmp_tab_t tab;
    rst_ni                  = 1'b0;
    cfg_we                  = 1'b0;
    cfg_index               = '0;
    cfg_data                = '0;
    sample_ch.valid         = 1'b0;
    sample_ch.second_tick   = 1'b0;
    sample_ch.button_levels = BtnReleased;
    time_ch.ready           = 1'b0;
    fail_count              = 0;
    results_seen            = 0;
    clock_now               = StateReset;
    prev_buttons            = BtnReleased;
    compare_tab             = CmpReset;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: single buttons, held buttons, level wrap, simultaneous edges
    push_sample(1'b1, 3'b111);
    push_sample(1'b0, 3'b111);
    push_sample(1'b0, 3'b110);
    push_sample(1'b1, 3'b110);
    push_sample(1'b0, 3'b111);
    push_sample(1'b0, 3'b101);
    push_sample(1'b0, 3'b101);
    push_sample(1'b0, 3'b011);
    push_sample(1'b0, 3'b111);
    push_sample(1'b0, 3'b011);
    push_sample(1'b1, 3'b111);
    push_sample(1'b1, 3'b000);
    push_sample(1'b0, 3'b000);
    push_sample(1'b1, 3'b111);
    push_sample(1'b0, 3'b100);
    push_sample(1'b0, 3'b111);
    push_sample(1'b0, 3'b010);
    push_sample(1'b1, 3'b001);
    push_sample(1'b0, 3'b111);
    queue_random_samples(PhaseItems);
    wait_drained();

    for (int phase = 1; phase < 6; phase++) begin
      case (phase)
        1:       tab = '{default: 8'h00};
        2:       tab = '{default: 8'hFF};
        3:       tab = '{8'd0, 8'd255, 8'd1, 8'd254};
        default: foreach (tab[i]) tab[i] = 8'($urandom_range(0, 255));
      endcase
      load_compare_table(tab);
      queue_random_samples(PhaseItems);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
